FILE: rtl/core/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg: shared types and constants of the Morse text codec
// Item formats, command codes passed from front to back, character codes.
// ----------------------------------------------------------------------------
package mtc_pkg;

    localparam int unsigned OPCODE_W   = 2;
    localparam int unsigned INDEX_W    = 6;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned LEN_W      = 3;
    localparam int unsigned PAT_W      = 5;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [LEN_W-1:0] MAX_CODE_LEN = 3'd5;

    localparam logic [OPCODE_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DATA = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EOL  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

    // register index, taken from paddr[2]
    localparam logic REG_MODE = 1'b0;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  entry_index;
        logic [CHAR_W-1:0]   entry_symbol;
        logic [LEN_W-1:0]    entry_length;
        logic [PAT_W-1:0]    entry_pattern;
        logic [CHAR_W-1:0]   in_char;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_of_run;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_LOAD,
        CMD_ENC_CHAR,
        CMD_ENC_SPACE,
        CMD_ENC_EOL,
        CMD_DEC_DOT,
        CMD_DEC_DASH,
        CMD_DEC_SPACE,
        CMD_DEC_EOL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [INDEX_W-1:0] index;
        logic [CHAR_W-1:0]  symbol;
        logic [LEN_W-1:0]   length;
        logic [PAT_W-1:0]   pattern;
        logic [CHAR_W-1:0]  data;
    } t_cmd;

    typedef struct packed {
        logic [CHAR_W-1:0] symbol;
        logic [LEN_W-1:0]  length;
        logic [PAT_W-1:0]  pattern;
    } t_entry;

endpackage

FILE: rtl/core/mtc_front.sv
// ----------------------------------------------------------------------------
// mtc_front: input side of the Morse text codec
// Holds the mode register, takes input items and turns them into commands.
// Items that have no effect are dropped here.
// ----------------------------------------------------------------------------
module mtc_front #(
    parameter int unsigned TABLE_ENTRIES = 36
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mtc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [mtc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [mtc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    input  mtc_pkg::t_in_item                 i_in_item,
    output logic                              o_in_stall,
    input  logic                              i_q_full,
    output logic                              o_cmd_push,
    output mtc_pkg::t_cmd                     o_cmd
);
    import mtc_pkg::*;

    localparam logic [INDEX_W:0] ENTRIES_LIM = (INDEX_W + 1)'(TABLE_ENTRIES);

    logic      r_mode;
    logic      s_keep;
    t_cmd_kind s_kind;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {{(CFG_DATA_W - 1){1'b0}}, r_mode}
                                           : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (psel && penable && pwrite && paddr[2] == REG_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    always_comb begin
        s_keep = 1'b0;
        s_kind = CMD_LOAD;
        unique case (i_in_item.opcode)
            OP_LOAD: begin
                s_kind = CMD_LOAD;
                s_keep = {1'b0, i_in_item.entry_index} < ENTRIES_LIM;
            end
            OP_DATA: begin
                if (r_mode == MODE_ENCODE) begin
                    s_keep = 1'b1;
                    s_kind = (i_in_item.in_char == CH_SPACE) ? CMD_ENC_SPACE : CMD_ENC_CHAR;
                end else begin
                    // stray characters in decode mode are dropped
                    unique case (i_in_item.in_char)
                        CH_DOT: begin
                            s_keep = 1'b1;
                            s_kind = CMD_DEC_DOT;
                        end
                        CH_DASH: begin
                            s_keep = 1'b1;
                            s_kind = CMD_DEC_DASH;
                        end
                        CH_SPACE: begin
                            s_keep = 1'b1;
                            s_kind = CMD_DEC_SPACE;
                        end
                        default: s_keep = 1'b0;
                    endcase
                end
            end
            OP_EOL: begin
                s_keep = 1'b1;
                s_kind = (r_mode == MODE_DECODE) ? CMD_DEC_EOL : CMD_ENC_EOL;
            end
            default: s_keep = 1'b0;
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_cmd_push = i_in_valid && !i_q_full && s_keep;

    always_comb begin
        o_cmd.kind    = s_kind;
        o_cmd.index   = i_in_item.entry_index;
        o_cmd.symbol  = i_in_item.entry_symbol;
        o_cmd.length  = i_in_item.entry_length;
        o_cmd.pattern = i_in_item.entry_pattern;
        o_cmd.data    = i_in_item.in_char;
    end

endmodule

FILE: rtl/core/mtc_queue.sv
// ----------------------------------------------------------------------------
// mtc_queue: command queue between front and back
// Small register FIFO; the head is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module mtc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output mtc_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import mtc_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_cmd   = r_q[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == DEPTH_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("command popped from empty queue");
`endif

endmodule

FILE: rtl/core/mtc_back.sv
// ----------------------------------------------------------------------------
// mtc_back: execution side of the Morse text codec
// Owns the code table memory and the decode state. Lookups walk the table
// one entry per cycle; results leave through a registered output stage.
// ----------------------------------------------------------------------------
module mtc_back #(
    parameter int unsigned TABLE_ENTRIES = 36
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_vld,
    input  mtc_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    output mtc_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import mtc_pkg::*;

    localparam int unsigned ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

    localparam logic [LEN_W-1:0] WORD_SPACE_RUN = 3'd4;
    localparam logic [LEN_W-1:0] RUN_RESET      = 3'd7;
    localparam logic [LEN_W-1:0] CHAR_GAP       = 3'd3;
    localparam logic [LEN_W-1:0] WORD_GAP       = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state            r_state;
    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd_ent;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;

    t_cmd_kind         r_kind;
    logic [CHAR_W-1:0] r_key;

    logic [PAT_W-1:0]  r_pend_pat;
    logic [LEN_W-1:0]  r_pend_len;
    logic [LEN_W-1:0]  r_space_run;

    // pending emission: symbol, code elements, spaces, newline, in that order
    logic              r_em_sym_vld;
    logic [CHAR_W-1:0] r_em_sym;
    logic [LEN_W-1:0]  r_em_elems;
    logic [PAT_W-1:0]  r_em_pat;
    logic [LEN_W-1:0]  r_em_spaces;
    logic              r_em_nl;

    logic              r_out_vld;
    t_out_item         r_out_item;

    logic [PAT_W-1:0]  s_mask;
    logic              s_match;
    logic              s_out_free;
    logic [CHAR_W-1:0] s_em_char;
    logic              s_em_last;
    logic [LEN_W-1:0]  s_run_next;
    logic [LEN_W-1:0]  s_enc_len;

    assign o_pop       = (r_state == S_IDLE) && i_cmd_vld;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;
    assign s_out_free  = !r_out_vld || !i_out_stall;
    assign s_run_next  = r_space_run + LEN_W'(1);
    assign s_enc_len   = (r_rd_ent.length > MAX_CODE_LEN) ? MAX_CODE_LEN : r_rd_ent.length;

    always_comb begin
        for (int i = 0; i < PAT_W; i++) begin
            s_mask[i] = LEN_W'(i) < r_pend_len;
        end
    end

    always_comb begin
        if (r_kind == CMD_ENC_CHAR) begin
            s_match = (r_rd_ent.symbol == r_key);
        end else begin
            s_match = (r_rd_ent.length == r_pend_len) &&
                      (((r_rd_ent.pattern ^ r_pend_pat) & s_mask) == '0);
        end
    end

    // read data always tracks the entry at r_addr
    always_comb begin
        n_addr = r_addr;
        if (r_state == S_IDLE) begin
            n_addr = '0;
        end else if (r_state == S_SCAN && !s_match && r_addr != LAST_ADDR) begin
            n_addr = r_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.kind == CMD_LOAD) begin
            r_mem[i_cmd.index[ADDR_W-1:0]] <= '{symbol:  i_cmd.symbol,
                                                length:  i_cmd.length,
                                                pattern: i_cmd.pattern};
        end
        r_rd_ent <= r_mem[n_addr];
    end

    always_comb begin
        s_em_char = CH_NL;
        s_em_last = 1'b1;
        if (r_em_sym_vld) begin
            s_em_char = r_em_sym;
            s_em_last = (r_em_elems == '0) && (r_em_spaces == '0) && !r_em_nl;
        end else if (r_em_elems != '0) begin
            s_em_char = r_em_pat[0] ? CH_DASH : CH_DOT;
            s_em_last = (r_em_elems == LEN_W'(1)) && (r_em_spaces == '0) && !r_em_nl;
        end else if (r_em_spaces != '0) begin
            s_em_char = CH_SPACE;
            s_em_last = (r_em_spaces == LEN_W'(1)) && !r_em_nl;
        end
    end

    // the emission flags and counts are all clear whenever the back returns to idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_addr       <= '0;
            r_out_vld    <= 1'b0;
            r_pend_pat   <= '0;
            r_pend_len   <= '0;
            r_space_run  <= '0;
            r_em_sym_vld <= 1'b0;
            r_em_elems   <= '0;
            r_em_spaces  <= '0;
            r_em_nl      <= 1'b0;
        end else begin
            r_addr <= n_addr;
            if (r_state == S_EMIT && s_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_kind <= i_cmd.kind;
                        r_key  <= i_cmd.data;
                        unique case (i_cmd.kind) inside
                            CMD_LOAD: begin
                                r_state <= S_IDLE;
                            end
                            CMD_ENC_CHAR: begin
                                r_state <= S_SCAN;
                            end
                            CMD_ENC_SPACE: begin
                                r_em_spaces <= WORD_GAP;
                                r_state     <= S_EMIT;
                            end
                            CMD_ENC_EOL: begin
                                r_em_nl <= 1'b1;
                                r_state <= S_EMIT;
                            end
                            CMD_DEC_DOT, CMD_DEC_DASH: begin
                                r_space_run <= '0;
                                if (r_pend_len >= MAX_CODE_LEN) begin
                                    // full code: look it up before taking the new element
                                    r_state <= S_SCAN;
                                end else begin
                                    if (i_cmd.kind == CMD_DEC_DASH) begin
                                        r_pend_pat <= r_pend_pat | (PAT_W'(1) << r_pend_len);
                                    end
                                    r_pend_len <= r_pend_len + LEN_W'(1);
                                end
                            end
                            CMD_DEC_SPACE: begin
                                r_space_run <= (s_run_next == RUN_RESET) ? '0 : s_run_next;
                                if (r_space_run == '0) begin
                                    if (r_pend_len != '0) begin
                                        r_state <= S_SCAN;
                                    end
                                end else if (s_run_next == WORD_SPACE_RUN) begin
                                    r_em_spaces <= LEN_W'(1);
                                    r_state     <= S_EMIT;
                                end
                            end
                            CMD_DEC_EOL: begin
                                r_space_run <= '0;
                                if (r_pend_len != '0) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_em_nl <= 1'b1;
                                    r_state <= S_EMIT;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (s_match || r_addr == LAST_ADDR) begin
                        r_em_sym_vld <= s_match && (r_kind != CMD_ENC_CHAR);
                        r_em_sym     <= r_rd_ent.symbol;
                        unique case (r_kind) inside
                            CMD_ENC_CHAR: begin
                                r_em_elems  <= s_match ? s_enc_len : '0;
                                r_em_pat    <= r_rd_ent.pattern;
                                r_em_spaces <= CHAR_GAP;
                                r_state     <= S_EMIT;
                            end
                            CMD_DEC_DOT, CMD_DEC_DASH: begin
                                r_pend_pat <= (r_kind == CMD_DEC_DASH) ? PAT_W'(1) : '0;
                                r_pend_len <= LEN_W'(1);
                                r_state    <= s_match ? S_EMIT : S_IDLE;
                            end
                            CMD_DEC_SPACE: begin
                                r_pend_pat <= '0;
                                r_pend_len <= '0;
                                r_state    <= s_match ? S_EMIT : S_IDLE;
                            end
                            CMD_DEC_EOL: begin
                                r_pend_pat <= '0;
                                r_pend_len <= '0;
                                r_em_nl    <= 1'b1;
                                r_state    <= S_EMIT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (s_out_free) begin
                        r_out_item <= '{out_char: s_em_char, last_of_run: s_em_last};
                        if (r_em_sym_vld) begin
                            r_em_sym_vld <= 1'b0;
                        end else if (r_em_elems != '0) begin
                            r_em_elems <= r_em_elems - LEN_W'(1);
                            r_em_pat   <= r_em_pat >> 1;
                        end else if (r_em_spaces != '0) begin
                            r_em_spaces <= r_em_spaces - LEN_W'(1);
                        end else begin
                            r_em_nl <= 1'b0;
                        end
                        if (s_em_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |->
            (r_em_sym_vld || r_em_elems != '0 || r_em_spaces != '0 || r_em_nl))
        else $error("emit state with nothing left to send");

    a_decode_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_len <= MAX_CODE_LEN) && (r_space_run != RUN_RESET))
        else $error("decode state out of range");

    a_scan_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.kind == CMD_ENC_CHAR) |=> (r_state == S_SCAN && r_addr == '0))
        else $error("table scan did not start at entry zero");

    a_emit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && s_out_free) |=> r_out_vld)
        else $error("emitted item not loaded into output register");
`endif

endmodule

FILE: rtl/core/morse_text_codec_unit.sv
// ----------------------------------------------------------------------------
// morse_text_codec_unit: Morse code encoder / decoder, top level
// Front classifies items, a four-entry command queue decouples it from the
// back, which runs table lookups and sends result characters.
// ----------------------------------------------------------------------------
// Timing: the input side takes one item per cycle until the four-entry
// command queue fills. The back handles a table load without leaving idle. A
// lookup (encoding a text character, or closing a pending Morse code) walks
// the table through its single read port, one entry per cycle, and stops at
// the first match. Each result character then passes through the output
// register, which holds it while the receiver stalls. An encoded character
// gives its code elements and three spaces, an encoded space four spaces; a
// decoded dot or dash is taken without leaving idle when no lookup is due.
// The table needs no clearing after reset; load every entry before use.
// ----------------------------------------------------------------------------
module morse_text_codec_unit #(
    parameter int unsigned TABLE_ENTRIES = 36
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mtc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mtc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mtc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    input  mtc_pkg::t_in_item              i_in_item,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output mtc_pkg::t_out_item             o_out_item,
    input  logic                           i_out_stall
);
    import mtc_pkg::*;

    t_cmd s_push_cmd;
    t_cmd s_head_cmd;
    logic s_push;
    logic s_pop;
    logic s_q_empty;
    logic s_q_full;

    mtc_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_full   (s_q_full),
        .o_cmd_push (s_push),
        .o_cmd      (s_push_cmd)
    );

    mtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_cmd   (s_push_cmd),
        .i_pop   (s_pop),
        .o_cmd   (s_head_cmd),
        .o_empty (s_q_empty),
        .o_full  (s_q_full)
    );

    mtc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_vld   (!s_q_empty),
        .i_cmd       (s_head_cmd),
        .o_pop       (s_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: dv/morse_text_codec_unit_tb.sv
// ----------------------------------------------------------------------------
// morse_text_codec_unit testbench
// Loads the code table, runs a short table of directed items in both modes,
// then random phases of text and Morse streams. Each result character is
// checked against its directed row or an in-bench codec model, under random
// sender bursts, receiver stalls and mode changes made while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
    import mtc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 36;
    localparam int MAX_OUT       = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 20;
    localparam int SETTLE_CYCLES = QUEUE_DEPTH * (TABLE_ENTRIES + 1 + MAX_OUT) + 20;
    localparam int CYCLE_LIMIT   = 500000;

    // opcode with no function, ignored by the unit
    localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

    typedef struct {
        int              set_mode;    // -1: keep the current mode
        t_in_item        item;
        int              n_exp;       // -1: expected chars come from the model
        logic [63:0]     exp_chars;   // char k at [8k +: 8]
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    t_in_item              i_in_item;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic                  i_out_stall = 1'b0;

    morse_text_codec_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(i_out_stall)
    );

    always #5ns i_clk = ~i_clk;

    // codec model state
    logic [CHAR_W-1:0] tbl_sym [TABLE_ENTRIES];
    logic [LEN_W-1:0]  tbl_len [TABLE_ENTRIES];
    logic [PAT_W-1:0]  tbl_pat [TABLE_ENTRIES];
    logic [PAT_W-1:0]  pend_pat;
    logic [LEN_W-1:0]  pend_len;
    logic [2:0]        space_cnt;
    logic              cur_mode;

    logic [CHAR_W-1:0] step_chars[$];
    t_out_item         chars_due[$];
    t_row              rows[$];
    int                next_mode = -1;

    int  err_cnt = 0;
    int  cyc = 0;
    int  burst_left = 0;
    int  items_sent = 0;
    bit  valid_up = 1'b0;

    int  stall_pct = 0;
    int  stall_cyc = 0;

    // ------------------------------------------------------------------
    // codec model
    // ------------------------------------------------------------------
    function automatic void put_char(logic [CHAR_W-1:0] c);
        if (step_chars.size() < MAX_OUT)
            step_chars.push_back(c);
    endfunction

    function automatic void close_code();
        int mask;
        bit hit;
        hit = 1'b0;
        if (pend_len == 0)
            return;
        mask = (1 << pend_len) - 1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!hit && tbl_len[i] == pend_len &&
                    (int'(tbl_pat[i]) & mask) == (int'(pend_pat) & mask)) begin
                put_char(tbl_sym[i]);
                hit = 1'b1;
            end
        end
        pend_pat = '0;
        pend_len = '0;
    endfunction

    function automatic void encode_char(logic [CHAR_W-1:0] c);
        int  n;
        bit  hit;
        hit = 1'b0;
        if (c == CH_SPACE) begin
            repeat (4) put_char(CH_SPACE);
            return;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!hit && tbl_sym[i] == c) begin
                hit = 1'b1;
                n = (tbl_len[i] > MAX_CODE_LEN) ? int'(MAX_CODE_LEN) : int'(tbl_len[i]);
                for (int k = 0; k < n; k++)
                    put_char(tbl_pat[i][k] ? CH_DASH : CH_DOT);
            end
        end
        repeat (3) put_char(CH_SPACE);
    endfunction

    function automatic void decode_char(logic [CHAR_W-1:0] c);
        if (c == CH_DOT || c == CH_DASH) begin
            space_cnt = '0;
            if (pend_len >= MAX_CODE_LEN)
                close_code();
            if (c == CH_DASH)
                pend_pat[pend_len] = 1'b1;
            pend_len = pend_len + 3'd1;
        end else if (c == CH_SPACE) begin
            if (space_cnt == 0)
                close_code();
            space_cnt = space_cnt + 3'd1;
            if (space_cnt == 4)
                put_char(CH_SPACE);
            if (space_cnt >= 7)
                space_cnt = '0;
        end
    endfunction

    function automatic void codec_step(t_in_item it);
        step_chars.delete();
        case (it.opcode)
            OP_LOAD: begin
                if (it.entry_index < TABLE_ENTRIES) begin
                    tbl_sym[it.entry_index] = it.entry_symbol;
                    tbl_len[it.entry_index] = it.entry_length;
                    tbl_pat[it.entry_index] = it.entry_pattern;
                end
            end
            OP_DATA: begin
                if (cur_mode == MODE_ENCODE)
                    encode_char(it.in_char);
                else
                    decode_char(it.in_char);
            end
            OP_EOL: begin
                if (cur_mode == MODE_DECODE) begin
                    close_code();
                    space_cnt = '0;
                end
                put_char(CH_NL);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic t_in_item ld_item(int idx, logic [CHAR_W-1:0] sym, int len, int pat);
        t_in_item it;
        it = t_in_item'($urandom);
        it.opcode        = OP_LOAD;
        it.entry_index   = INDEX_W'(idx);
        it.entry_symbol  = sym;
        it.entry_length  = LEN_W'(len);
        it.entry_pattern = PAT_W'(pat);
        return it;
    endfunction

    function automatic t_in_item char_item(logic [CHAR_W-1:0] c);
        t_in_item it;
        it = t_in_item'($urandom);
        it.opcode  = OP_DATA;
        it.in_char = c;
        return it;
    endfunction

    function automatic t_in_item eol_item();
        t_in_item it;
        it = t_in_item'($urandom);
        it.opcode = OP_EOL;
        return it;
    endfunction

    function automatic void add_row(t_in_item it, int n_exp, string s);
        t_row r;
        r.set_mode  = next_mode;
        r.item      = it;
        r.n_exp     = n_exp;
        r.exp_chars = '0;
        for (int k = 0; k < s.len(); k++)
            r.exp_chars[8*k +: 8] = s[k];
        rows.push_back(r);
        next_mode = -1;
    endfunction

    function automatic void add_model(t_in_item it);
        add_row(it, -1, "");
    endfunction

    function automatic void add_typed(t_in_item it, string s);
        add_row(it, s.len(), s);
    endfunction

    function automatic void build_rows();
        t_in_item it;
        // no table reads before the table is loaded
        next_mode = int'(MODE_ENCODE);
        add_typed(eol_item(), "\n");
        add_typed(char_item(CH_SPACE), "    ");
        it = t_in_item'(32'hFFFF_FFFF);
        it.opcode = OP_NONE;
        add_typed(it, "");
        add_typed(ld_item(63, 8'hFF, 7, 31), "");
        next_mode = int'(MODE_DECODE);
        add_typed(char_item(8'h78), "");
        repeat (7) add_model(char_item(CH_SPACE));
        add_typed(eol_item(), "\n");

        // every code of length 1..4 plus six of length 5, symbols A-Z then 0-9
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i < 2)       it = ld_item(i, CHAR_W'(8'h41 + i), 1, i);
            else if (i < 6)  it = ld_item(i, CHAR_W'(8'h41 + i), 2, i - 2);
            else if (i < 14) it = ld_item(i, CHAR_W'(8'h41 + i), 3, i - 6);
            else if (i < 26) it = ld_item(i, CHAR_W'(8'h41 + i), 4, i - 14);
            else if (i < 30) it = ld_item(i, CHAR_W'(8'h30 + i - 26), 4, i - 14);
            else             it = ld_item(i, CHAR_W'(8'h30 + i - 26), 5, i - 30);
            add_typed(it, "");
        end

        next_mode = int'(MODE_ENCODE);
        add_model(char_item("A"));
        add_typed(char_item(8'h00), "   ");
        add_typed(ld_item(35, 8'hFF, 7, 31), "");
        add_typed(char_item(8'hFF), "-----   ");
        add_typed(ld_item(34, 8'h00, 0, 0), "");
        add_typed(char_item(8'h00), "   ");
        // duplicate symbol in a higher slot: lowest slot wins
        add_typed(ld_item(33, "A", 2, 3), "");
        add_model(char_item("A"));
        add_typed(eol_item(), "\n");

        next_mode = int'(MODE_DECODE);
        add_model(char_item(CH_DASH));
        add_model(char_item(CH_DOT));
        add_model(char_item(CH_SPACE));
        // sixth element closes a full code
        repeat (6) add_model(char_item(CH_DOT));
        add_model(eol_item());
        // five dashes match no slot
        repeat (5) add_model(char_item(CH_DASH));
        add_model(char_item(CH_SPACE));
        add_typed(char_item(8'hFF), "");
        add_typed(eol_item(), "\n");
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send(t_in_item it, int n_exp, logic [63:0] exp_chars);
        t_out_item e;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        valid_up = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        codec_step(it);
        if (n_exp >= 0) begin
            for (int k = 0; k < n_exp; k++) begin
                e.out_char    = exp_chars[8*k +: 8];
                e.last_of_run = (k == n_exp - 1);
                chars_due.push_back(e);
            end
        end else begin
            for (int k = 0; k < step_chars.size(); k++) begin
                e.out_char    = step_chars[k];
                e.last_of_run = (k == step_chars.size() - 1);
                chars_due.push_back(e);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic send_model(t_in_item it);
        bit ignored;
        ignored = (it.opcode == OP_NONE) ||
                  (it.opcode == OP_DATA && cur_mode == MODE_DECODE &&
                   it.in_char != CH_DOT && it.in_char != CH_DASH && it.in_char != CH_SPACE);
        if (!ignored)
            items_sent++;
        send(it, -1, '0);
    endtask

    task automatic hold_in();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        hold_in();
        while (chars_due.size() != 0) @(posedge i_clk);
        // loads and ignored items produce nothing, so let the back finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(logic m);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({REG_MODE, 2'b00});
        pwdata  <= CFG_DATA_W'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cur_mode = m;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== m) begin
            $display("%0t: mode readback expected %0b got %0b", $time, m, prdata[0]);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Morse for a random table slot, then a gap of spaces most of the time
    task automatic send_morse_word();
        int  idx;
        int  n;
        bit  known;
        bit  dash;
        int  r;
        idx   = $urandom_range(0, TABLE_ENTRIES - 1);
        known = (tbl_len[idx] >= 1 && tbl_len[idx] <= MAX_CODE_LEN);
        n     = known ? int'(tbl_len[idx]) : $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            dash = known ? tbl_pat[idx][k] : 1'($urandom_range(0, 1));
            send_model(char_item(dash ? CH_DASH : CH_DOT));
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            n = 0;
        else if (r < 7)
            n = 1;
        else if (r < 9)
            n = $urandom_range(2, 5);
        else
            n = $urandom_range(6, 9);
        repeat (n) send_model(char_item(CH_SPACE));
    endtask

    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_model(ld_item($urandom_range(0, 63), 8'($urandom), $urandom_range(0, 7),
                               $urandom_range(0, 31)));
        else if (r < 14)
            send_model(t_in_item'($urandom));
        else if (r < 18)
            send_model(eol_item());
        else if (cur_mode == MODE_DECODE)
            send_morse_word();
        else if (r < 75)
            send_model(char_item(tbl_sym[$urandom_range(0, TABLE_ENTRIES - 1)]));
        else if (r < 88)
            send_model(char_item(CH_SPACE));
        else
            send_model(char_item(8'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // output side: stall pattern and checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected item, expected none got char %h last %b",
                         $time, o_out_item.out_char, o_out_item.last_of_run);
                err_cnt++;
            end else begin
                e = chars_due.pop_front();
                if (o_out_item.out_char !== e.out_char) begin
                    $display("%0t: out_char expected %h got %h",
                             $time, e.out_char, o_out_item.out_char);
                    err_cnt++;
                end
                if (o_out_item.last_of_run !== e.last_of_run) begin
                    $display("%0t: last_of_run expected %b got %b",
                             $time, e.last_of_run, o_out_item.last_of_run);
                    err_cnt++;
                end
            end
        end
        stall_cyc++;
        if (stall_cyc % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc == CYCLE_LIMIT) begin
            $display("morse_text_codec_unit: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        pend_pat  = '0;
        pend_len  = '0;
        space_cnt = '0;
        cur_mode  = MODE_ENCODE;
        build_rows();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].set_mode >= 0)
                set_mode(rows[r].set_mode[0]);
            send(rows[r].item, rows[r].n_exp, rows[r].exp_chars);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_mode((p % 2 == 0) ? MODE_ENCODE : MODE_DECODE);
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                send_random_item();
        end

        wait_idle();
        if (err_cnt == 0 && chars_due.size() == 0)
            $display("morse_text_codec_unit: match");
        else
            $display("morse_text_codec_unit: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mtc_pkg.sv
rtl/core/mtc_front.sv
rtl/core/mtc_queue.sv
rtl/core/mtc_back.sv
rtl/core/morse_text_codec_unit.sv
dv/morse_text_codec_unit_tb.sv
